[rtl/edd_pkg.sv]
// Package for the error diffusion dither block: beat types, constants and
// the clamped error share function. No dependencies.
package edd_pkg;

   localparam int WIDTH_W = 9;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd190;
   localparam logic [7:0] INK_LIMIT = 8'd128;
   localparam logic [7:0] WHITE_LEVEL = 8'd255;

   localparam logic [2:0] WT_ABOVE_LEFT = 3'd1;
   localparam logic [2:0] WT_ABOVE = 3'd5;
   localparam logic [2:0] WT_ABOVE_RIGHT = 3'd3;
   localparam logic [2:0] WT_LEFT = 3'd7;

   typedef struct packed {
      logic [7:0] gray_level;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic ink;
      logic row_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] above_left;
      logic [7:0] above_mid;
      logic [7:0] above_right;
      logic [7:0] left;
   } window_type;

   // Adds the weighted sixteenth of a signed error to a pixel value, with the
   // share truncated toward zero and the sum clamped to 0..255.
   function automatic logic [7:0] add_share(input logic [7:0] value,
                                            input logic [7:0] err,
                                            input logic [2:0] wt);
      logic signed [11:0] err_x;
      logic signed [11:0] wt_x;
      logic signed [11:0] prod;
      logic signed [11:0] share;
      logic signed [11:0] sum;
      err_x = {{4{err[7]}}, err};
      wt_x = {9'd0, wt};
      prod = err_x * wt_x;
      if (prod[11]) begin
         share = (prod + 12'sd15) >>> 4;
      end else begin
         share = prod >>> 4;
      end
      sum = $signed({4'd0, value}) + share;
      if (sum[11]) begin
         add_share = 8'd0;
      end else if (sum > 12'sd255) begin
         add_share = WHITE_LEVEL;
      end else begin
         add_share = sum[7:0];
      end
   endfunction

endpackage

[rtl/edd_line_mem.sv]
// Line store of the errors of the row above: one write port and two read
// ports with registered read data. Depends on nothing.
module edd_line_mem #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [7:0]    rd_data_a,
   output logic [7:0]    rd_data_b,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/edd_kernel.sv]
// Per-pixel arithmetic: four clamped error additions, the ink decision and
// the new error. Depends on edd_pkg.
module edd_kernel (
   input  logic [7:0]          gray_level,
   input  edd_pkg::window_type win,
   output logic                ink,
   output logic [7:0]          err,
   output logic [7:0]          above_mid
);
   import edd_pkg::*;

   logic [7:0] v1;
   logic [7:0] v2;
   logic [7:0] v3;
   logic [7:0] v4;

   always_comb begin
      v1 = add_share(gray_level, win.above_left, WT_ABOVE_LEFT);
      v2 = add_share(v1, win.above_mid, WT_ABOVE);
      v3 = add_share(v2, win.above_right, WT_ABOVE_RIGHT);
      v4 = add_share(v3, win.left, WT_LEFT);
      ink = v4 < INK_LIMIT;
      err = ink ? v4 : v4 - WHITE_LEVEL;
   end

   assign above_mid = win.above_mid;

endmodule

[rtl/error_diffusion_dither_top.sv]
// Top level of the Floyd-Steinberg error diffusion dither.
// Depends on edd_pkg, edd_line_mem and edd_kernel.
//
// Pixels arrive in raster order on the req_ channel, one beat per pixel, and
// each gives exactly one rsp_ beat with the ink bit and a row end flag.
// A beat moves when valid is high and stall is low; the receiver drives stall.
// The csr_ channel writes the image width (1 to MAX_WIDTH pixels, zero counts
// as one, larger values saturate); write it only while no pixel is in flight.
// Set frame_start on the first pixel of every image; after reset the stream
// is taken as an image that began at reset.
// An accepted pixel reads the row above from the line store at that edge,
// is computed in the following cycle and lands in the output register when
// the compute stage advances, which waits while the output register is stalled.
// The block takes one pixel every cycle while the output is not stalled; the
// rate is set by the feedback loop that reads the line store, adds the four
// error shares and writes the new error back. Two pixels can wait while
// rsp_stall is high, one in the compute stage and one in the output
// register; after that req_stall rises. Reset clears the pipeline and sets
// the width to 190. The line store needs no clearing after reset.
module error_diffusion_dither_top #(
   parameter int MAX_WIDTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  edd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output edd_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [edd_pkg::WIDTH_W-1:0]   csr_image_width
);
   import edd_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

   logic [WIDTH_W-1:0] width_ff;
   logic [AW-1:0]      col_ff;
   logic [AW-1:0]      col_in;
   logic               first_row_ff;
   logic               first_row_in;

   logic               s1_valid_ff;
   logic [7:0]         s1_gray_ff;
   logic [AW-1:0]      s1_x_ff;
   logic               s1_last_ff;
   logic               s1_first_ff;
   logic               fwd_a_ff;
   logic               fwd_b_ff;
   logic [7:0]         fwd_err_ff;

   logic [7:0]         above_left_ff;
   logic [7:0]         above_left_in;
   logic [7:0]         left_ff;
   logic [7:0]         left_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [CW-1:0]      width_ext;
   logic [AW-1:0]      last_col;
   logic [AW-1:0]      acc_x;
   logic               acc_first;
   logic               acc_last;
   logic [AW-1:0]      addr_b;
   logic               req_accept;
   logic               s1_adv;

   logic [7:0]         rd_a;
   logic [7:0]         rd_b;
   logic [7:0]         mid_raw;
   logic [7:0]         right_raw;
   window_type         win;
   logic               k_ink;
   logic [7:0]         k_err;
   logic [7:0]         k_mid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_image_width;
      end
   end

   always_comb begin
      width_ext = CW'(width_ff);
      if (width_ext == '0) begin
         last_col = '0;
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         last_col = AW'(MAX_WIDTH - 1);
      end else begin
         last_col = AW'(width_ext - CW'(1));
      end
   end

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_data.frame_start) begin
         acc_x = '0;
         acc_first = 1'b1;
      end else begin
         acc_x = (col_ff > last_col) ? last_col : col_ff;
         acc_first = first_row_ff;
      end
      acc_last = acc_x == last_col;
      addr_b = acc_x + AW'(1);
      col_in = acc_last ? '0 : acc_x + AW'(1);
      first_row_in = acc_last ? 1'b0 : acc_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         first_row_ff <= 1'b1;
      end else if (req_accept) begin
         col_ff <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_gray_ff <= req_data.gray_level;
         s1_x_ff <= acc_x;
         s1_last_ff <= acc_last;
         s1_first_ff <= acc_first;
         fwd_a_ff <= s1_adv && (s1_x_ff == acc_x);
         fwd_b_ff <= s1_adv && (s1_x_ff == addr_b);
         fwd_err_ff <= k_err;
      end
   end

   edd_line_mem #(
      .DEPTH(MAX_WIDTH),
      .AW(AW)
   ) u_line_mem (
      .clock(clock),
      .rd_en(req_accept),
      .rd_addr_a(acc_x),
      .rd_addr_b(addr_b),
      .rd_data_a(rd_a),
      .rd_data_b(rd_b),
      .wr_en(s1_adv),
      .wr_addr(s1_x_ff),
      .wr_data(k_err)
   );

   always_comb begin
      mid_raw = fwd_a_ff ? fwd_err_ff : rd_a;
      right_raw = fwd_b_ff ? fwd_err_ff : rd_b;
      win.above_left = (s1_x_ff == '0 || s1_first_ff) ? 8'd0 : above_left_ff;
      win.above_mid = s1_first_ff ? 8'd0 : mid_raw;
      win.above_right = (s1_first_ff || s1_last_ff) ? 8'd0 : right_raw;
      win.left = (s1_x_ff == '0) ? 8'd0 : left_ff;
   end

   edd_kernel u_kernel (
      .gray_level(s1_gray_ff),
      .win(win),
      .ink(k_ink),
      .err(k_err),
      .above_mid(k_mid)
   );

   assign above_left_in = s1_last_ff ? 8'd0 : k_mid;
   assign left_in = s1_last_ff ? 8'd0 : k_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         above_left_ff <= '0;
         left_ff <= '0;
      end else if (s1_adv) begin
         above_left_ff <= above_left_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff.ink <= k_ink;
         rsp_data_ff.row_end <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_adv_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("compute stage advanced without filling the output register");

   a_row_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && acc_last) |=> (col_ff == '0 && !first_row_ff))
      else $error("column did not wrap after the last pixel of a row");

   a_first_row_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(first_row_ff) |-> $past(req_accept && acc_last))
      else $error("first row flag cleared away from a row end");

   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline could move");

endmodule
